### hw/rtl/sparse_triplet_matrix_multiply_top_assert.svh
// Assertion macros, clocked on clk and disabled while arst_n is low.
`ifndef SPARSE_TRIPLET_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define SPARSE_TRIPLET_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// same-cycle implication
`define STMM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STMM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/stmm_pkg.sv
package stmm_pkg;

	localparam int ENTRIES_DEF    = 64;
	localparam int DIM_DEF        = 256;
	localparam int RESULT_MAX_DEF = 63;
	localparam int VALUE_BITS_DEF = 16;

	localparam int IDX_W     = 8;
	localparam int IN_VAL_W  = 16;
	localparam int OUT_VAL_W = 40;
	localparam int CNT_W     = 6;
	localparam int STATUS_W  = 2;
	localparam int KIND_W    = 2;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 2 * IDX_W + IN_VAL_W;
	localparam int OUT_W     = 2 * IDX_W + OUT_VAL_W + CNT_W + STATUS_W;

	localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RES_OVF  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LOAD_OVF = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;

	// column counter write data select
	localparam logic [1:0] CSW_ZERO = 2'd0;
	localparam logic [1:0] CSW_RUN  = 2'd1;
	localparam logic [1:0] CSW_INC  = 2'd2;

	typedef struct packed {
		logic       load;
		logic       run_clr;
		logic       run_add;
		logic       cs_we;
		logic       cs_scan;
		logic [1:0] cs_wsel;
		logic       bc_we;
		logic       latch;
		logic       acc;
		logic       emit;
		logic       summ;
		logic       summ_ovf;
		logic       clear;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic load_ovf;
		logic mismatch;
		logic a_row_eq;
		logic b_row_eq;
		logic col_eq;
		logic col_lt;
		logic sum_nz;
		logic out_free;
	} stat_t;

endpackage

### hw/rtl/stmm_ctrl.sv
module stmm_ctrl #(
	parameter int ENTRIES    = stmm_pkg::ENTRIES_DEF,
	parameter int DIM        = stmm_pkg::DIM_DEF,
	parameter int RESULT_MAX = stmm_pkg::RESULT_MAX_DEF,
	localparam int CW = $clog2(ENTRIES + 1),
	localparam int DW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  stmm_pkg::stat_t            st,
	input  logic [CW-1:0]              na,
	input  logic [CW-1:0]              nb,
	output stmm_pkg::cmd_t             cmd,
	output logic [CW-1:0]              i_idx,
	output logic [CW-1:0]              j_idx,
	output logic [DW-1:0]              t_idx,
	output logic [stmm_pkg::CNT_W-1:0] k_cnt
);
	import stmm_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CLR   = 5'd1;
	localparam logic [4:0] S_CNT_F = 5'd2;
	localparam logic [4:0] S_CNT_R = 5'd3;
	localparam logic [4:0] S_CNT_W = 5'd4;
	localparam logic [4:0] S_PFX_R = 5'd5;
	localparam logic [4:0] S_PFX_W = 5'd6;
	localparam logic [4:0] S_SCT_F = 5'd7;
	localparam logic [4:0] S_SCT_R = 5'd8;
	localparam logic [4:0] S_SCT_W = 5'd9;
	localparam logic [4:0] S_OUTER = 5'd10;
	localparam logic [4:0] S_FETCH = 5'd11;
	localparam logic [4:0] S_COLST = 5'd12;
	localparam logic [4:0] S_INNER = 5'd13;
	localparam logic [4:0] S_EMIT  = 5'd14;
	localparam logic [4:0] S_SKIP  = 5'd15;
	localparam logic [4:0] S_ROWSK = 5'd16;
	localparam logic [4:0] S_SUMM  = 5'd17;

	logic [4:0]       state_q, state_n, ret_q, ret_n;
	logic [CW-1:0]    i_q, i_n, j_q, j_n, i1_q, i1_n;
	logic [DW-1:0]    t_q, t_n;
	logic [CNT_W-1:0] k_q, k_n;
	logic             rovf_q, rovf_n;
	logic             i_lt, j_lt, t_last, go;

	assign i_lt   = i_q < na;
	assign j_lt   = j_q < nb;
	assign t_last = t_q == DW'(DIM - 1);

	always_comb begin
		state_n = state_q;
		ret_n   = ret_q;
		i_n     = i_q;
		j_n     = j_q;
		i1_n    = i1_q;
		t_n     = t_q;
		k_n     = k_q;
		rovf_n  = rovf_q;
		go      = 1'b0;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid && st.start) begin
					i_n         = '0;
					j_n         = '0;
					t_n         = '0;
					k_n         = '0;
					rovf_n      = 1'b0;
					cmd.run_clr = 1'b1;
					if (st.load_ovf || st.mismatch || nb == '0)
						state_n = S_SUMM;
					else
						state_n = S_CLR;
				end
			end
			S_CLR: begin
				cmd.cs_we   = 1'b1;
				cmd.cs_scan = 1'b1;
				cmd.cs_wsel = CSW_ZERO;
				t_n         = t_q + DW'(1);
				if (t_last) begin
					t_n     = '0;
					state_n = S_CNT_F;
				end
			end
			S_CNT_F: state_n = S_CNT_R;
			S_CNT_R: state_n = S_CNT_W;
			S_CNT_W: begin
				cmd.cs_we   = 1'b1;
				cmd.cs_wsel = CSW_INC;
				i_n         = i_q + CW'(1);
				state_n     = S_CNT_F;
				if (i_q + CW'(1) == nb) begin
					i_n     = '0;
					state_n = S_PFX_R;
				end
			end
			S_PFX_R: begin
				cmd.cs_scan = 1'b1;
				state_n     = S_PFX_W;
			end
			S_PFX_W: begin
				cmd.cs_we   = 1'b1;
				cmd.cs_scan = 1'b1;
				cmd.cs_wsel = CSW_RUN;
				cmd.run_add = 1'b1;
				t_n         = t_q + DW'(1);
				state_n     = S_PFX_R;
				if (t_last) begin
					t_n     = '0;
					state_n = S_SCT_F;
				end
			end
			S_SCT_F: state_n = S_SCT_R;
			S_SCT_R: state_n = S_SCT_W;
			S_SCT_W: begin
				cmd.cs_we   = 1'b1;
				cmd.cs_wsel = CSW_INC;
				cmd.bc_we   = 1'b1;
				i_n         = i_q + CW'(1);
				state_n     = S_SCT_F;
				if (i_q + CW'(1) == nb) begin
					i_n     = '0;
					state_n = S_OUTER;
				end
			end
			S_OUTER: begin
				if (!i_lt) begin
					state_n = S_SUMM;
				end else begin
					i1_n    = i_q;
					j_n     = '0;
					ret_n   = S_COLST;
					state_n = S_FETCH;
				end
			end
			S_FETCH: state_n = ret_q;
			S_COLST: begin
				cmd.latch = 1'b1;
				state_n   = S_INNER;
			end
			S_INNER: begin
				if (i_lt && j_lt && st.a_row_eq && st.b_row_eq) begin
					if (st.col_eq) begin
						cmd.acc = 1'b1;
						i_n     = i_q + CW'(1);
						j_n     = j_q + CW'(1);
					end else if (st.col_lt) begin
						i_n = i_q + CW'(1);
					end else begin
						j_n = j_q + CW'(1);
					end
					ret_n   = S_INNER;
					state_n = S_FETCH;
				end else begin
					state_n = S_EMIT;
				end
			end
			S_EMIT: begin
				go = 1'b1;
				if (st.sum_nz) begin
					if (k_q >= CNT_W'(RESULT_MAX)) begin
						rovf_n  = 1'b1;
						state_n = S_SUMM;
						go      = 1'b0;
					end else if (st.out_free) begin
						cmd.emit = 1'b1;
						k_n      = k_q + CNT_W'(1);
					end else begin
						go = 1'b0;
					end
				end
				if (go) begin
					if (j_lt)
						i_n = i1_q;
					ret_n   = S_SKIP;
					state_n = S_FETCH;
				end
			end
			S_SKIP: begin
				if (j_lt && st.b_row_eq) begin
					j_n     = j_q + CW'(1);
					ret_n   = S_SKIP;
					state_n = S_FETCH;
				end else if (j_lt) begin
					state_n = S_COLST;
				end else begin
					state_n = S_ROWSK;
				end
			end
			S_ROWSK: begin
				if (i_lt && st.a_row_eq) begin
					i_n     = i_q + CW'(1);
					ret_n   = S_ROWSK;
					state_n = S_FETCH;
				end else begin
					state_n = S_OUTER;
				end
			end
			S_SUMM: begin
				if (st.out_free) begin
					cmd.summ     = 1'b1;
					cmd.summ_ovf = rovf_q;
					cmd.clear    = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			i1_q    <= '0;
			t_q     <= '0;
			k_q     <= '0;
			rovf_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			ret_q   <= ret_n;
			i_q     <= i_n;
			j_q     <= j_n;
			i1_q    <= i1_n;
			t_q     <= t_n;
			k_q     <= k_n;
			rovf_q  <= rovf_n;
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign i_idx    = i_q;
	assign j_idx    = j_q;
	assign t_idx    = t_q;
	assign k_cnt    = k_q;

`include "sparse_triplet_matrix_multiply_top_assert.svh"

	`STMM_ASSERT_IMP(a_k_bound, 1'b1, k_q <= CNT_W'(RESULT_MAX), "entry count beyond limit")
	`STMM_ASSERT_IMP(a_emit_ok, cmd.emit, st.out_free && st.sum_nz, "entry emitted without room")
	`STMM_ASSERT_NXT(a_summ_idle, cmd.summ, state_q == S_IDLE && k_q == k_cnt, "no idle after summary")

endmodule

### hw/rtl/stmm_dpath.sv
module stmm_dpath #(
	parameter int ENTRIES    = stmm_pkg::ENTRIES_DEF,
	parameter int DIM        = stmm_pkg::DIM_DEF,
	parameter int VALUE_BITS = stmm_pkg::VALUE_BITS_DEF,
	localparam int CW = $clog2(ENTRIES + 1),
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int DW = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [stmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stmm_pkg::CFG_W-1:0]     cfg_data,
	input  logic [stmm_pkg::IN_W-1:0]      s_tdata,
	input  logic [stmm_pkg::KIND_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [stmm_pkg::OUT_W-1:0]     m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast,
	input  stmm_pkg::cmd_t                 cmd,
	output stmm_pkg::stat_t                st,
	output logic [CW-1:0]                  na,
	output logic [CW-1:0]                  nb,
	input  logic [CW-1:0]                  i_idx,
	input  logic [CW-1:0]                  j_idx,
	input  logic [DW-1:0]                  t_idx,
	input  logic [stmm_pkg::CNT_W-1:0]     k_cnt
);
	import stmm_pkg::*;

	localparam int PW = 2 * VALUE_BITS;
	localparam int SW = (PW + CW > OUT_VAL_W) ? PW + CW : OUT_VAL_W;

	logic [IDX_W-1:0]      in_row, in_col;
	logic [VALUE_BITS-1:0] in_val;
	logic                  in_rng, ld_a, ld_b, full_a, full_b;

	logic [CFG_W-1:0] a_cols_q, b_rows_q;
	logic [CW-1:0]    na_q, nb_q, run_q;
	logic             lovf_q;

	logic [IDX_W-1:0]      a_row_m [ENTRIES];
	logic [IDX_W-1:0]      a_col_m [ENTRIES];
	logic [VALUE_BITS-1:0] a_val_m [ENTRIES];
	logic [IDX_W-1:0]      b_row_m [ENTRIES];
	logic [IDX_W-1:0]      b_col_m [ENTRIES];
	logic [VALUE_BITS-1:0] b_val_m [ENTRIES];
	logic [IDX_W-1:0]      bc_row_m[ENTRIES];
	logic [IDX_W-1:0]      bc_col_m[ENTRIES];
	logic [VALUE_BITS-1:0] bc_val_m[ENTRIES];
	logic [CW-1:0]         cs_m    [DIM];

	logic [IDX_W-1:0]      a_row_q, a_col_q, b_row_q, b_col_q, bc_row_q, bc_col_q;
	logic [VALUE_BITS-1:0] a_val_q, b_val_q, bc_val_q;
	logic [CW-1:0]         cs_q, cs_wdata;
	logic [DW-1:0]         cs_addr;

	logic [IDX_W-1:0]      r_q, c_q;
	logic signed [PW-1:0]  prod;
	logic signed [SW-1:0]  sum_q;

	logic                  o_valid_q, o_summ_q;
	logic [IDX_W-1:0]      o_row_q, o_col_q;
	logic [OUT_VAL_W-1:0]  o_val_q;
	logic [CNT_W-1:0]      o_cnt_q;
	logic [STATUS_W-1:0]   o_status_q, summ_status;

	assign in_row = s_tdata[IDX_W-1:0];
	assign in_col = s_tdata[2*IDX_W-1:IDX_W];
	assign in_val = VALUE_BITS'(s_tdata[IN_W-1:2*IDX_W]);
	assign in_rng = (32'(in_row) < DIM) && (32'(in_col) < DIM);
	assign full_a = na_q == CW'(ENTRIES);
	assign full_b = nb_q == CW'(ENTRIES);
	assign ld_a   = cmd.load && s_tuser == KIND_LOAD_A && in_rng;
	assign ld_b   = cmd.load && s_tuser == KIND_LOAD_B && in_rng;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cols_q <= CFG_W'(256);
			b_rows_q <= CFG_W'(256);
			na_q     <= '0;
			nb_q     <= '0;
			lovf_q   <= 1'b0;
			run_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_A_COLS)
				a_cols_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_B_ROWS)
				b_rows_q <= cfg_data;
			if (ld_a) begin
				if (full_a)
					lovf_q <= 1'b1;
				else
					na_q <= na_q + CW'(1);
			end
			if (ld_b) begin
				if (full_b)
					lovf_q <= 1'b1;
				else
					nb_q <= nb_q + CW'(1);
			end
			if (cmd.clear) begin
				na_q   <= '0;
				nb_q   <= '0;
				lovf_q <= 1'b0;
			end
			if (cmd.run_clr)
				run_q <= '0;
			else if (cmd.run_add)
				run_q <= run_q + cs_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_a && !full_a) begin
			a_row_m[na_q[AW-1:0]] <= in_row;
			a_col_m[na_q[AW-1:0]] <= in_col;
			a_val_m[na_q[AW-1:0]] <= in_val;
		end
		a_row_q <= a_row_m[i_idx[AW-1:0]];
		a_col_q <= a_col_m[i_idx[AW-1:0]];
		a_val_q <= a_val_m[i_idx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ld_b && !full_b) begin
			b_row_m[nb_q[AW-1:0]] <= in_row;
			b_col_m[nb_q[AW-1:0]] <= in_col;
			b_val_m[nb_q[AW-1:0]] <= in_val;
		end
		b_row_q <= b_row_m[i_idx[AW-1:0]];
		b_col_q <= b_col_m[i_idx[AW-1:0]];
		b_val_q <= b_val_m[i_idx[AW-1:0]];
	end

	// transposed B: row and column swapped
	always_ff @(posedge clk) begin
		if (cmd.bc_we) begin
			bc_row_m[cs_q[AW-1:0]] <= b_col_q;
			bc_col_m[cs_q[AW-1:0]] <= b_row_q;
			bc_val_m[cs_q[AW-1:0]] <= b_val_q;
		end
		bc_row_q <= bc_row_m[j_idx[AW-1:0]];
		bc_col_q <= bc_col_m[j_idx[AW-1:0]];
		bc_val_q <= bc_val_m[j_idx[AW-1:0]];
	end

	assign cs_addr = cmd.cs_scan ? t_idx : DW'(b_col_q);

	always_comb begin
		case (cmd.cs_wsel)
			CSW_ZERO: cs_wdata = '0;
			CSW_RUN:  cs_wdata = run_q;
			CSW_INC:  cs_wdata = cs_q + CW'(1);
			default:  cs_wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cs_we)
			cs_m[cs_addr] <= cs_wdata;
		cs_q <= cs_m[cs_addr];
	end

	assign prod = $signed(a_val_q) * $signed(bc_val_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			r_q   <= a_row_q;
			c_q   <= bc_row_q;
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SW'(prod);
		end
	end

	always_comb begin
		if (lovf_q)
			summ_status = ST_LOAD_OVF;
		else if (st.mismatch)
			summ_status = ST_MISMATCH;
		else if (cmd.summ_ovf)
			summ_status = ST_RES_OVF;
		else
			summ_status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_valid_q <= 1'b0;
		else if (cmd.emit || cmd.summ)
			o_valid_q <= 1'b1;
		else if (m_tready)
			o_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_row_q    <= r_q;
			o_col_q    <= c_q;
			o_val_q    <= sum_q[OUT_VAL_W-1:0];
			o_cnt_q    <= '0;
			o_status_q <= ST_OK;
			o_summ_q   <= 1'b0;
		end else if (cmd.summ) begin
			o_row_q    <= '0;
			o_col_q    <= '0;
			o_val_q    <= '0;
			o_cnt_q    <= k_cnt;
			o_status_q <= summ_status;
			o_summ_q   <= 1'b1;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {o_status_q, o_cnt_q, o_val_q, o_col_q, o_row_q};
	assign m_tuser  = o_summ_q;
	assign m_tlast  = o_summ_q;

	assign st.start    = s_tuser == KIND_START;
	assign st.load_ovf = lovf_q;
	assign st.mismatch = a_cols_q != b_rows_q;
	assign st.a_row_eq = a_row_q == r_q;
	assign st.b_row_eq = bc_row_q == c_q;
	assign st.col_eq   = a_col_q == bc_col_q;
	assign st.col_lt   = a_col_q < bc_col_q;
	assign st.sum_nz   = sum_q != '0;
	assign st.out_free = !o_valid_q || m_tready;

	assign na = na_q;
	assign nb = nb_q;

endmodule

### hw/rtl/sparse_triplet_matrix_multiply_top.sv
// Load beats are kind A or B; s_tready is high whenever idle.
// A start beat runs a counter clear over all DIM columns, a count pass over the B
// entries, a prefix sum over the columns, a scatter pass over the B entries, then
// the merge, with a fetch state before each step on the single read port of each store, plus output stalls.
// Reset clears counts, flags and the output valid; stores need no clearing.
module sparse_triplet_matrix_multiply_top #(
	parameter int ENTRIES    = stmm_pkg::ENTRIES_DEF,
	parameter int DIM        = stmm_pkg::DIM_DEF,
	parameter int RESULT_MAX = stmm_pkg::RESULT_MAX_DEF,
	parameter int VALUE_BITS = stmm_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [stmm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stmm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [stmm_pkg::IN_W-1:0]      s_tdata,  // row, col, value
	input  logic [stmm_pkg::KIND_W-1:0]    s_tuser,  // kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [stmm_pkg::OUT_W-1:0]     m_tdata,  // out_row, out_col, out_value, entry_count, status
	output logic                           m_tuser,  // is_summary
	output logic                           m_tlast
);
	import stmm_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;

	cmd_t             cmd;
	stat_t            st;
	logic [CW-1:0]    na, nb, i_idx, j_idx;
	logic [DW-1:0]    t_idx;
	logic [CNT_W-1:0] k_cnt;

	stmm_ctrl #(
		.ENTRIES(ENTRIES),
		.DIM(DIM),
		.RESULT_MAX(RESULT_MAX)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.st(st),
		.na(na),
		.nb(nb),
		.cmd(cmd),
		.i_idx(i_idx),
		.j_idx(j_idx),
		.t_idx(t_idx),
		.k_cnt(k_cnt)
	);

	stmm_dpath #(
		.ENTRIES(ENTRIES),
		.DIM(DIM),
		.VALUE_BITS(VALUE_BITS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cmd(cmd),
		.st(st),
		.na(na),
		.nb(nb),
		.i_idx(i_idx),
		.j_idx(j_idx),
		.t_idx(t_idx),
		.k_cnt(k_cnt)
	);

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import stmm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;
	localparam int NSTORE = 64;
	localparam int NDIM = 256;
	localparam int PRODUCT_MAX = 63;
	localparam int STALL_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 260;

	typedef struct {
		logic [7:0] r;
		logic [7:0] c;
		logic signed [15:0] v;
	} triple_t;

	typedef struct {
		logic [7:0] row;
		logic [7:0] col;
		logic [39:0] value;
		logic summ;
		logic [5:0] cnt;
		logic [1:0] st;
		logic lst;
	} product_t;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] r;
		logic [7:0] c;
		logic [15:0] v;
		bit typed;
		logic [5:0] t_cnt;
		logic [1:0] t_st;
	} vector_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	sparse_triplet_matrix_multiply_top uut (.*);

	always #1 clk = ~clk;

	triple_t a_ent[NSTORE];
	triple_t b_ent[NSTORE];
	triple_t b_col[NSTORE];
	int a_num = 0;
	int b_num = 0;
	bit drop_flag = 0;
	logic [8:0] dims[4] = '{9'd256, 9'd256, 9'd256, 9'd256};
	product_t pending[$];
	int errors = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit calm = 0;
	bit long_hold = 0;

	function automatic void sort_columns();
		int start[NDIM];
		int run;
		int t;
		for (int c = 0; c < NDIM; c++) start[c] = 0;
		for (int i = 0; i < b_num; i++) start[b_ent[i].c]++;
		run = 0;
		for (int c = 0; c < NDIM; c++) begin
			t = start[c];
			start[c] = run;
			run += t;
		end
		for (int i = 0; i < b_num; i++) begin
			t = start[b_ent[i].c]++;
			if (t < NSTORE) begin
				b_col[t].r = b_ent[i].c;
				b_col[t].c = b_ent[i].r;
				b_col[t].v = b_ent[i].v;
			end
		end
	endfunction

	function automatic int multiply_rows(output bit ovf);
		int i, i1, j, k;
		logic [7:0] r, c;
		longint sum;
		product_t p;
		bit done;
		k = 0;
		ovf = 0;
		done = 0;
		i = 0;
		if (b_num == 0) return 0;
		while (i < a_num && !done) begin
			i1 = i;
			j = 0;
			r = a_ent[i].r;
			while (j < b_num && !done) begin
				c = b_col[j].r;
				sum = 0;
				r = a_ent[i].r;
				while (i < a_num && j < b_num && a_ent[i].r == r && b_col[j].r == c) begin
					if (a_ent[i].c == b_col[j].c) begin
						sum += longint'(a_ent[i].v) * longint'(b_col[j].v);
						i++;
						j++;
					end else if (a_ent[i].c < b_col[j].c) begin
						i++;
					end else begin
						j++;
					end
				end
				if (sum != 0) begin
					if (k >= PRODUCT_MAX) begin
						ovf = 1;
						done = 1;
					end else begin
						p = '{row: r, col: c, value: sum[39:0], summ: 0, cnt: 0, st: ST_OK,
							lst: 0};
						pending.push_back(p);
						k++;
					end
				end
				if (!done) begin
					if (j < b_num) i = i1;
					while (j < b_num && b_col[j].r == c) j++;
				end
			end
			if (!done)
				while (i < a_num && a_ent[i].r == r) i++;
		end
		return k;
	endfunction

	function automatic void predict_beat(vector_t x);
		int k;
		bit ovf;
		logic [1:0] st;
		product_t p;
		k = 0;
		st = ST_OK;
		if (x.kind == KIND_LOAD_A || x.kind == KIND_LOAD_B) begin
			if ((x.kind == KIND_LOAD_A ? a_num : b_num) >= NSTORE) begin
				drop_flag = 1;
			end else if (x.kind == KIND_LOAD_A) begin
				a_ent[a_num] = '{x.r, x.c, x.v};
				a_num++;
			end else begin
				b_ent[b_num] = '{x.r, x.c, x.v};
				b_num++;
			end
		end else if (x.kind == KIND_START) begin
			if (drop_flag) begin
				st = ST_LOAD_OVF;
			end else if (dims[CFG_A_COLS] != dims[CFG_B_ROWS]) begin
				st = ST_MISMATCH;
			end else begin
				sort_columns();
				k = multiply_rows(ovf);
				if (ovf) st = ST_RES_OVF;
			end
			if (x.typed) begin
				k = x.t_cnt;
				st = x.t_st;
			end
			p = '{row: 0, col: 0, value: 0, summ: 1, cnt: k[5:0], st: st, lst: 1};
			pending.push_back(p);
			a_num = 0;
			b_num = 0;
			drop_flag = 0;
		end
	endfunction

	task automatic send_beat(vector_t x);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= x.kind;
		s_tdata <= {x.v, x.c, x.r};
		do @(posedge clk); while (!s_tready);
		predict_beat(x);
		items_sent++;
	endtask

	task automatic load(logic [1:0] kind, logic [7:0] r, logic [7:0] c, logic [15:0] v);
		vector_t x;
		x = '{kind: kind, r: r, c: c, v: v, typed: 0, t_cnt: 0, t_st: 0};
		send_beat(x);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_dims(logic [8:0] ar, logic [8:0] ac, logic [8:0] br, logic [8:0] bc);
		logic [8:0] v[4];
		v = '{ar, ac, br, bc};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1;
			cfg_index <= i[1:0];
			cfg_data <= v[i];
			@(posedge clk);
			dims[i] = v[i];
		end
		cfg_we <= 0;
	endtask

	// random run: mostly row-major sorted loads in a small index range
	task automatic random_run(int na, int nb, bit sorted, bit wide);
		triple_t t[$];
		triple_t s;
		int m;
		for (int side = 0; side < 2; side++) begin
			t.delete();
			for (int i = 0; i < (side == 0 ? na : nb); i++) begin
				s.r = wide ? 8'($urandom) : 8'($urandom_range(0, 5));
				s.c = wide ? 8'($urandom) : 8'($urandom_range(0, 5));
				s.v = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($signed($urandom_range(0, 20)) - 10);
				if (s.v == 0) s.v = 1;
				t.push_back(s);
			end
			if (sorted)
				for (int i = 1; i < t.size(); i++) begin
					s = t[i];
					m = i;
					while (m > 0 && {t[m-1].r, t[m-1].c} > {s.r, s.c}) begin
						t[m] = t[m-1];
						m--;
					end
					t[m] = s;
				end
			foreach (t[i])
				load(side == 0 ? KIND_LOAD_A : KIND_LOAD_B, t[i].r, t[i].c, t[i].v);
			if ($urandom_range(0, 5) == 0)
				load(KIND_NONE, 8'($urandom), 8'($urandom), 16'($urandom));
		end
		load(KIND_START, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// receiver with random stall per beat
	int stall_left = 0;
	always @(posedge clk) begin
		product_t e;
		product_t g;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				quiet_cycles <= 0;
				g = '{row: m_tdata[7:0], col: m_tdata[15:8], value: m_tdata[55:16],
					summ: m_tuser, cnt: m_tdata[61:56], st: m_tdata[63:62], lst: m_tlast};
				if (pending.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = pending.pop_front();
					if (g.row !== e.row) begin
						$error("out_row expected %0d got %0d", e.row, g.row); errors++;
					end
					if (g.col !== e.col) begin
						$error("out_col expected %0d got %0d", e.col, g.col); errors++;
					end
					if (g.value !== e.value) begin
						$error("out_value expected %0d got %0d", $signed(e.value),
							$signed(g.value));
						errors++;
					end
					if (g.summ !== e.summ) begin
						$error("is_summary expected %0d got %0d", e.summ, g.summ); errors++;
					end
					if (g.cnt !== e.cnt) begin
						$error("entry_count expected %0d got %0d", e.cnt, g.cnt); errors++;
					end
					if (g.st !== e.st) begin
						$error("status expected %0d got %0d", e.st, g.st); errors++;
					end
					if (g.lst !== e.lst) begin
						$error("last expected %0d got %0d", e.lst, g.lst); errors++;
					end
				end
				stall_left = calm ? 0 : $urandom_range(0, 11);
			end else if (s_tvalid && s_tready) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (long_hold) begin
				stall_left = 2000;
				long_hold = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	vector_t directed[] = '{
		'{KIND_START, 8'd0, 8'd0, 16'd0, 1, 6'd0, ST_OK},
		'{KIND_LOAD_A, 8'd0, 8'd0, 16'h7fff, 0, 0, 0},
		'{KIND_LOAD_B, 8'd0, 8'd0, 16'h7fff, 0, 0, 0},
		'{KIND_START, 8'd0, 8'd0, 16'd0, 0, 0, 0},
		'{KIND_LOAD_A, 8'd0, 8'd1, 16'd1, 0, 0, 0},
		'{KIND_LOAD_A, 8'd255, 8'd255, 16'h8000, 0, 0, 0},
		'{KIND_LOAD_B, 8'd1, 8'd0, 16'd3, 0, 0, 0},
		'{KIND_LOAD_B, 8'd255, 8'd255, 16'h8000, 0, 0, 0},
		'{KIND_NONE, 8'hff, 8'hff, 16'hffff, 0, 0, 0},
		'{KIND_START, 8'hff, 8'hff, 16'hffff, 0, 0, 0},
		'{KIND_LOAD_A, 8'd2, 8'd0, 16'd1, 0, 0, 0},
		'{KIND_LOAD_A, 8'd2, 8'd1, 16'd1, 0, 0, 0},
		'{KIND_LOAD_B, 8'd0, 8'd4, 16'd1, 0, 0, 0},
		'{KIND_LOAD_B, 8'd1, 8'd4, 16'hffff, 0, 0, 0},
		'{KIND_START, 8'd0, 8'd0, 16'd0, 1, 6'd0, ST_OK},
		'{KIND_LOAD_B, 8'd3, 8'd3, 16'd5, 0, 0, 0},
		'{KIND_START, 8'd0, 8'd0, 16'd0, 1, 6'd0, ST_OK},
		'{KIND_LOAD_A, 8'd3, 8'd2, 16'd7, 0, 0, 0},
		'{KIND_LOAD_A, 8'd1, 8'd2, 16'hfff9, 0, 0, 0},
		'{KIND_LOAD_B, 8'd2, 8'd1, 16'd2, 0, 0, 0},
		'{KIND_LOAD_B, 8'd2, 8'd0, 16'd3, 0, 0, 0},
		'{KIND_START, 8'd0, 8'd0, 16'd0, 0, 0, 0}
	};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) send_beat(directed[i]);

		// load overflow: one beat past a full A store
		for (int i = 0; i <= NSTORE; i++) load(KIND_LOAD_A, 8'd0, 8'(i), 16'd1);
		load(KIND_LOAD_B, 8'd0, 8'd0, 16'd1);
		load(KIND_START, 8'd0, 8'd0, 16'd0);

		// result overflow: outer product of 8 by 8, receiver held off
		calm = 1;
		for (int i = 0; i < 8; i++) load(KIND_LOAD_A, 8'(i), 8'd0, 16'(i + 1));
		for (int i = 0; i < 8; i++) load(KIND_LOAD_B, 8'd0, 8'(i), 16'(i + 1));
		long_hold = 1;
		load(KIND_START, 8'd0, 8'd0, 16'd0);
		calm = 0;
		for (int i = 0; i < 6; i++) load(KIND_LOAD_A, 8'(i), 8'd1, 16'(i + 2));
		load(KIND_START, 8'd0, 8'd0, 16'd0);

		set_dims(9'd1, 9'd1, 9'd1, 9'd1);
		random_run(3, 3, 1, 0);
		set_dims(9'd4, 9'd7, 9'd9, 9'd4);
		load(KIND_LOAD_A, 8'd0, 8'd0, 16'd2);
		load(KIND_LOAD_B, 8'd0, 8'd0, 16'd2);
		load(KIND_START, 8'd0, 8'd0, 16'd0);
		set_dims(9'd6, 9'd6, 9'd6, 9'd6);

		while (items_sent < RANDOM_ITEMS + directed.size()) begin
			calm = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0: random_run($urandom_range(0, 8), $urandom_range(0, 8), 0, 1);
				1: random_run($urandom_range(0, 6), $urandom_range(0, 6), 0, 0);
				2: begin
					drain();
					random_run($urandom_range(1, 12), $urandom_range(1, 12), 1, 0);
				end
				default: random_run($urandom_range(1, 12), $urandom_range(1, 12), 1, 0);
			endcase
		end
		calm = 0;
		set_dims(9'd256, 9'd256, 9'd256, 9'd256);
		random_run(10, 10, 1, 0);

		drain();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
